[src/mvcg_pkg.sv]
package mvcg_pkg;

	// Grid height limits in weeks.
	localparam logic [2:0] MIN_WEEKS = 3'd5;
	localparam logic [2:0] MAX_WEEKS = 3'd6;

	// Reciprocal multipliers: floor(x * R >> 17) equals x / D over the ranges used here.
	localparam logic [12:0] RECIP_25 = 13'd5243;
	localparam logic [14:0] RECIP_7  = 15'd18725;
	localparam int unsigned RECIP_SHIFT = 17;

	// Offset that keeps the Gregorian cycle and avoids negative years.
	localparam logic [13:0] YEAR_BIAS = 14'd400;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_MAR = 4'd3;
	localparam logic [3:0] MONTH_DEC = 4'd12;
	localparam logic [13:0] YEAR_MAX = 14'd9999;

	// Sequencer steps, one control word each.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIAS,
		ST_CENT,
		ST_SUM,
		ST_DIV7,
		ST_WDAY,
		ST_SETUP,
		ST_EMIT
	} step_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_WAIT_IN,
		JMP_LOOP_LAST
	} jmp_t;

	typedef struct packed {
		logic  in_ready;
		logic  ld_bias;
		logic  ld_cent;
		logic  ld_sum;
		logic  ld_div7;
		logic  ld_wday;
		logic  ld_setup;
		logic  emit;
		jmp_t  jmp;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		logic in_fire;
		logic last_fire;
	} stat_t;

	function automatic ctrl_t ucode_rom(input step_t s);
		ctrl_t c;
		c = '0;
		c.jmp = JMP_NEXT;
		c.target = ST_IDLE;
		unique case (s)
			ST_IDLE: begin
				c.in_ready = 1'b1;
				c.jmp = JMP_WAIT_IN;
			end
			ST_BIAS:  c.ld_bias = 1'b1;
			ST_CENT:  c.ld_cent = 1'b1;
			ST_SUM:   c.ld_sum = 1'b1;
			ST_DIV7:  c.ld_div7 = 1'b1;
			ST_WDAY:  c.ld_wday = 1'b1;
			ST_SETUP: c.ld_setup = 1'b1;
			ST_EMIT: begin
				c.emit = 1'b1;
				c.jmp = JMP_LOOP_LAST;
				c.target = ST_IDLE;
			end
		endcase
		return c;
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
		logic [4:0] d;
		case (mo)
			4'd2:                       d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:    d = 5'd30;
			default:                    d = 5'd31;
		endcase
		return d;
	endfunction

	// Month offsets of the weekday formula.
	function automatic logic [2:0] month_offset(input logic [3:0] mo);
		logic [2:0] r;
		case (mo)
			4'd2, 4'd6:  r = 3'd3;
			4'd3, 4'd11: r = 3'd2;
			4'd4, 4'd10: r = 3'd5;
			4'd7:        r = 3'd5;
			4'd8:        r = 3'd1;
			4'd9, 4'd12: r = 3'd4;
			4'd5:        r = 3'd0;
			default:     r = 3'd0;
		endcase
		// October is 6, a value not shared with another month.
		if (mo == 4'd10) r = 3'd6;
		if (mo == 4'd4) r = 3'd5;
		return r;
	endfunction

endpackage

[src/mvcg_if.sv]
interface mvcg_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  req_month;
	logic [13:0] req_year;
	logic [13:0] today_year;
	logic [3:0]  today_month;
	logic [4:0]  today_day;

	modport source (output valid, req_month, req_year, today_year, today_month, today_day,
		input ready);
	modport sink (input valid, req_month, req_year, today_year, today_month, today_day,
		output ready);
endinterface

interface mvcg_cell_if;
	logic               valid;
	logic               ready;
	logic [4:0]         cell_day;
	logic [3:0]         cell_month;
	logic signed [14:0] cell_year;
	logic               in_month;
	logic               is_past;
	logic               last_cell;

	modport source (output valid, cell_day, cell_month, cell_year, in_month, is_past, last_cell,
		input ready);
	modport sink (input valid, cell_day, cell_month, cell_year, in_month, is_past, last_cell,
		output ready);
endinterface

[src/month_view_calendar_grid_core.sv]
// After the request transfer the control program steps through ST_BIAS, ST_CENT,
// ST_SUM, ST_DIV7, ST_WDAY and ST_SETUP, then emits one cell per cycle while the
// sink takes them. A grid holds 35 or 42 cells.
// The request channel is ready only in the idle step; the cell output register
// lets the next request transfer while the final cell still waits.
// Reset clears the step counter and the output valid flag.
module month_view_calendar_grid_core
	import mvcg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	mvcg_req_if.sink     req,
	mvcg_cell_if.source  grid
);

	ctrl_t ctrl;
	stat_t stat;

	mvcg_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	mvcg_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.grid   (grid),
		.ctrl   (ctrl),
		.stat   (stat)
	);

endmodule

[src/mvcg_seq.sv]
module mvcg_seq
	import mvcg_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	step_t step_q;
	step_t step_d;

	assign ctrl = ucode_rom(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		step_d = step_q;
		unique case (ctrl.jmp)
			JMP_NEXT: begin
				step_d = step_t'(step_q + 3'd1);
			end
			JMP_WAIT_IN: begin
				if (stat.in_fire) step_d = step_t'(step_q + 3'd1);
			end
			JMP_LOOP_LAST: begin
				if (stat.last_fire) step_d = ctrl.target;
			end
			default: step_d = ST_IDLE;
		endcase
	end

endmodule

[src/mvcg_dp.sv]
module mvcg_dp
	import mvcg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	mvcg_req_if.sink            req,
	mvcg_cell_if.source         grid,
	input  ctrl_t               ctrl,
	output stat_t               stat
);

	// Request registers.
	logic [3:0]  m_q;
	logic [13:0] y_q;
	logic [13:0] ty_q;
	logic [3:0]  tm_q;
	logic [4:0]  td_q;

	// Weekday and month-length working registers.
	logic [13:0] yy_q;
	logic [9:0]  qy25_q;
	logic [6:0]  q100_q;
	logic        leap_q;
	logic [13:0] sum_q;
	logic [10:0] q7_q;
	logic [2:0]  fdow_q;
	logic [4:0]  dim_q;

	// Walk state.
	logic [5:0]         total_q;
	logic [5:0]         count_q;
	logic [4:0]         walk_day_q;
	logic [3:0]         walk_month_q;
	logic signed [14:0] walk_year_q;

	// Output register.
	logic               out_valid_q;
	logic [4:0]         out_day_q;
	logic [3:0]         out_month_q;
	logic signed [14:0] out_year_q;
	logic               out_in_month_q;
	logic               out_past_q;
	logic               out_last_q;

	logic        in_fire;
	logic        emit_fire;
	logic        is_last;
	logic [3:0]  m_clamp;
	logic [13:0] y_clamp;
	logic [26:0] prod_y25;
	logic [23:0] prod_c25;
	logic [28:0] prod_7;
	logic [13:0] rem25;
	logic [2:0]  dow;
	logic [5:0]  need;
	logic [2:0]  wk_raw;
	logic [2:0]  wk;
	logic [3:0]  prev_m;
	logic [4:0]  prev_days;
	logic [4:0]  cur_days;
	logic        past;
	logic        in_m;
	logic signed [15:0] wy_ext;
	logic signed [15:0] ty_ext;

	assign req.ready = ctrl.in_ready;
	assign in_fire   = req.valid && ctrl.in_ready;
	assign emit_fire = ctrl.emit && (!out_valid_q || grid.ready);
	assign is_last   = (count_q + 6'd1) == total_q;

	assign stat.in_fire   = in_fire;
	assign stat.last_fire = emit_fire && is_last;

	always_comb begin
		m_clamp = req.req_month;
		if (req.req_month == 4'd0) m_clamp = MONTH_JAN;
		else if (req.req_month > MONTH_DEC) m_clamp = MONTH_DEC;
		y_clamp = (req.req_year > YEAR_MAX) ? YEAR_MAX : req.req_year;

		prod_y25 = 27'(y_q) * 27'(RECIP_25);
		prod_c25 = 24'(yy_q[13:2]) * 24'(RECIP_25);
		prod_7   = 29'(sum_q) * 29'(RECIP_7);
		rem25    = y_q - 14'({qy25_q, 4'b0} + {qy25_q, 3'b0} + 14'(qy25_q));
		dow      = 3'(sum_q - 14'({q7_q, 3'b0} - 14'(q7_q)));

		need = 6'(fdow_q) + 6'(dim_q);
		if (need <= 6'd28)      wk_raw = 3'd4;
		else if (need <= 6'd35) wk_raw = 3'd5;
		else                    wk_raw = 3'd6;
		wk = (wk_raw < MIN_WEEKS) ? MIN_WEEKS : wk_raw;
		if (wk > MAX_WEEKS) wk = MAX_WEEKS;

		prev_m    = (m_q == MONTH_JAN) ? MONTH_DEC : m_q - 4'd1;
		prev_days = month_days(prev_m, leap_q);
		// February only ever appears in the grid with the requested year.
		cur_days  = month_days(walk_month_q, leap_q);

		wy_ext = 16'(walk_year_q);
		ty_ext = signed'({2'b00, ty_q});
		past = (wy_ext < ty_ext) ||
			((wy_ext == ty_ext) && ((walk_month_q < tm_q) ||
			((walk_month_q == tm_q) && (walk_day_q < td_q))));
		in_m = (walk_month_q == m_q) && (walk_year_q == signed'({1'b0, y_q}));
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			m_q  <= m_clamp;
			y_q  <= y_clamp;
			ty_q <= req.today_year;
			tm_q <= req.today_month;
			td_q <= req.today_day;
		end
		if (ctrl.ld_bias) begin
			yy_q   <= y_q + YEAR_BIAS - 14'(m_q < MONTH_MAR);
			qy25_q <= prod_y25[RECIP_SHIFT +: 10];
		end
		if (ctrl.ld_cent) begin
			q100_q <= prod_c25[RECIP_SHIFT +: 7];
			leap_q <= (y_q[1:0] == 2'b00) && ((rem25 != 14'd0) || (y_q[3:0] == 4'd0));
		end
		if (ctrl.ld_sum) begin
			sum_q <= yy_q + 14'(yy_q[13:2]) - 14'(q100_q) + 14'(q100_q[6:2])
				+ 14'(month_offset(m_q)) + 14'd1;
		end
		if (ctrl.ld_div7) begin
			q7_q <= prod_7[RECIP_SHIFT +: 11];
		end
		if (ctrl.ld_wday) begin
			// Formula gives 0 for Sunday; the grid counts from Monday.
			fdow_q <= (dow == 3'd0) ? 3'd6 : dow - 3'd1;
			dim_q  <= month_days(m_q, leap_q);
		end
		if (ctrl.ld_setup) begin
			total_q <= 6'(wk) * 6'd7;
			count_q <= 6'd0;
			if (fdow_q != 3'd0) begin
				walk_day_q   <= prev_days - 5'(fdow_q) + 5'd1;
				walk_month_q <= prev_m;
				walk_year_q  <= signed'({1'b0, y_q}) - 15'(m_q == MONTH_JAN);
			end else begin
				walk_day_q   <= 5'd1;
				walk_month_q <= m_q;
				walk_year_q  <= signed'({1'b0, y_q});
			end
		end
		if (emit_fire) begin
			out_day_q      <= walk_day_q;
			out_month_q    <= walk_month_q;
			out_year_q     <= walk_year_q;
			out_in_month_q <= in_m;
			out_past_q     <= past;
			out_last_q     <= is_last;
			count_q        <= count_q + 6'd1;
			if (walk_day_q >= cur_days) begin
				walk_day_q <= 5'd1;
				if (walk_month_q == MONTH_DEC) begin
					walk_month_q <= MONTH_JAN;
					walk_year_q  <= walk_year_q + 15'sd1;
				end else begin
					walk_month_q <= walk_month_q + 4'd1;
				end
			end else begin
				walk_day_q <= walk_day_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (grid.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign grid.valid      = out_valid_q;
	assign grid.cell_day   = out_day_q;
	assign grid.cell_month = out_month_q;
	assign grid.cell_year  = out_year_q;
	assign grid.in_month   = out_in_month_q;
	assign grid.is_past    = out_past_q;
	assign grid.last_cell  = out_last_q;

endmodule
